@@ rtl/stb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Shared sizes, result codes and record types of the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int SLOT_IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DUR_W       = 32;
  localparam int SLOT_W      = 4;
  localparam int EV_W        = 2;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  // Result codes carried in tuser
  localparam logic [EV_W-1:0] EV_CREATED = 2'd0;
  localparam logic [EV_W-1:0] EV_FULL    = 2'd1;
  localparam logic [EV_W-1:0] EV_EXPIRED = 2'd2;

  // Input kind codes
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_CREATE = 1'b1;

  // One slot record as stored in the slot memory
  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic [DUR_W-1:0] count;
    logic             single_shot;
    logic             notify;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // One result handed from the sequencer to the output register
  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } stb_res_t;

  // Low SLOT_W bits of a slot index, zero-extended for small banks
  function automatic logic [SLOT_W-1:0] slot_field(input slot_idx_t idx);
    logic [SLOT_IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

@@ rtl/software_timer_bank_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// Bank of periodic and one-shot timer slots driven by create and tick items.
// ----------------------------------------------------------------------------
// A create transfer claims the lowest inactive slot and answers with one
// result (created, or bank full with slot 0) once the result register is
// free. A tick transfer walks every slot in index order through the slot
// memory over its single registered read port, one slot per cycle while
// no expiry result is held up by back-pressure on the result register.
// Each notifying expiry yields one expired result, and the last of them
// carries tlast; a tick without notifying expiries yields none.
// Active marks live in flip-flops cleared by reset, so no clearing pass is
// needed. A new item is taken once the previous one has pushed all results;
// the final result may still wait in the output register.
module software_timer_bank_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] duration, [32] single_shot, [33] notify
  input  logic        in_tuser,   // [0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] slot
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast
);

  stb_pkg::slot_entry_t ram_wdata;
  stb_pkg::slot_entry_t ram_rdata;
  stb_pkg::slot_idx_t   ram_waddr;
  stb_pkg::slot_idx_t   ram_raddr;
  logic                 ram_we;

  logic                 out_free;
  logic                 res_push;
  stb_pkg::stb_res_t    res;

  logic                 out_vld_r, out_vld_nxt;
  stb_pkg::stb_res_t    out_res_r, out_res_nxt;

  // Output register frees up in the same cycle its transfer completes
  assign out_free = !out_vld_r || out_tready;

  stb_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_vld         (in_tvalid),
    .item_rdy         (in_tready),
    .item_kind        (in_tuser),
    .item_duration    (in_tdata[stb_pkg::DUR_W-1:0]),
    .item_single_shot (in_tdata[32]),
    .item_notify      (in_tdata[33]),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_free         (out_free),
    .res_push         (res_push),
    .res              (res)
  );

  stb_slot_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Load a pushed result, otherwise drop the register once it is taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (res_push) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_res_r.slot};
  assign out_tuser  = out_res_r.event_res;
  assign out_tlast  = out_res_r.last;

endmodule

@@ rtl/stb_slot_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_slot_ram
// Slot record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stb_slot_ram (
  input  logic                  clk,
  input  logic                  we,
  input  stb_pkg::slot_idx_t    waddr,
  input  stb_pkg::slot_entry_t  wdata,
  input  stb_pkg::slot_idx_t    raddr,
  output stb_pkg::slot_entry_t  rdata_r
);

  stb_pkg::slot_entry_t mem [stb_pkg::NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/stb_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_seq
// Item sequencer: slot allocation on create, read-modify-write walk on tick.
// ----------------------------------------------------------------------------
module stb_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  // accepted input item
  input  logic                   item_vld,
  output logic                   item_rdy,
  input  logic                   item_kind,
  input  logic [stb_pkg::DUR_W-1:0] item_duration,
  input  logic                   item_single_shot,
  input  logic                   item_notify,
  // slot memory
  output logic                   ram_we,
  output stb_pkg::slot_idx_t     ram_waddr,
  output stb_pkg::slot_entry_t   ram_wdata,
  output stb_pkg::slot_idx_t     ram_raddr,
  input  stb_pkg::slot_entry_t   ram_rdata,
  // result push into the output register
  input  logic                   out_free,
  output logic                   res_push,
  output stb_pkg::stb_res_t      res
);

  typedef enum logic [1:0] {ST_IDLE, ST_CREATE, ST_WALK, ST_FLUSH} state_t;

  state_t                         state_r, state_nxt;
  logic [stb_pkg::NUM_TIMERS-1:0] active_r, active_nxt;
  stb_pkg::slot_idx_t             q_r, q_nxt;
  stb_pkg::slot_idx_t             pend_r, pend_nxt;
  logic                           pend_vld_r, pend_vld_nxt;
  logic [stb_pkg::RES_CNT_W-1:0]  nres_r, nres_nxt;
  logic [stb_pkg::DUR_W-1:0]      dur_r, dur_nxt;
  logic                           ss_r, ss_nxt;
  logic                           nt_r, nt_nxt;

  logic                           have_free;
  stb_pkg::slot_idx_t             free_idx;
  logic [stb_pkg::DUR_W-1:0]      cnt_inc;
  logic                           expired;
  logic                           emit;
  logic                           stall;

  // Lowest inactive slot
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = stb_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        have_free = 1'b1;
        free_idx  = stb_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  // Slot under update in the walk: count can't wrap, it never exceeds duration
  assign cnt_inc = ram_rdata.count + stb_pkg::DUR_W'(1);
  assign expired = (cnt_inc >= ram_rdata.duration);
  assign emit    = active_r[q_r] && expired && ram_rdata.notify &&
                   (nres_r < stb_pkg::RES_CNT_W'(stb_pkg::MAX_RESULTS));
  assign stall   = (state_r == ST_WALK) && emit && pend_vld_r && !out_free;

  assign item_rdy = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    q_nxt        = q_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    nres_nxt     = nres_r;
    dur_nxt      = dur_r;
    ss_nxt       = ss_r;
    nt_nxt       = nt_r;
    ram_we       = 1'b0;
    ram_waddr    = q_r;
    ram_wdata    = ram_rdata;
    ram_raddr    = q_r + stb_pkg::SLOT_IDX_W'(1);
    res_push     = 1'b0;
    res          = '{event_res: stb_pkg::EV_EXPIRED,
                     slot: stb_pkg::slot_field(pend_r), last: 1'b0};

    case (state_r)
      ST_IDLE: begin
        ram_raddr = '0;
        if (item_vld) begin
          dur_nxt = item_duration;
          ss_nxt  = item_single_shot;
          nt_nxt  = item_notify;
          if (item_kind == stb_pkg::KIND_CREATE) begin
            state_nxt = ST_CREATE;
          end else begin
            // slot 0 read issued now, its record arrives on the first walk cycle
            q_nxt        = '0;
            nres_nxt     = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_WALK;
          end
        end
      end

      ST_CREATE: begin
        if (out_free) begin
          res_push = 1'b1;
          state_nxt = ST_IDLE;
          if (have_free) begin
            ram_we               = 1'b1;
            ram_waddr            = free_idx;
            ram_wdata.duration   = dur_r;
            ram_wdata.count      = '0;
            ram_wdata.single_shot = ss_r;
            ram_wdata.notify     = nt_r;
            active_nxt[free_idx] = 1'b1;
            res = '{event_res: stb_pkg::EV_CREATED,
                    slot: stb_pkg::slot_field(free_idx), last: 1'b1};
          end else begin
            res = '{event_res: stb_pkg::EV_FULL, slot: '0, last: 1'b1};
          end
        end
      end

      ST_WALK: begin
        if (stall) begin
          // hold the slot and re-read it
          ram_raddr = q_r;
        end else begin
          if (active_r[q_r]) begin
            ram_we          = 1'b1;
            ram_wdata.count = expired ? '0 : cnt_inc;
            if (expired && ram_rdata.single_shot) begin
              active_nxt[q_r] = 1'b0;
            end
          end
          if (emit) begin
            // the held expiry is not the last one: release it
            res_push     = pend_vld_r;
            pend_nxt     = q_r;
            pend_vld_nxt = 1'b1;
            nres_nxt     = nres_r + stb_pkg::RES_CNT_W'(1);
          end
          q_nxt = q_r + stb_pkg::SLOT_IDX_W'(1);
          if (q_r == stb_pkg::SLOT_IDX_W'(stb_pkg::NUM_TIMERS - 1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          res_push     = 1'b1;
          res.last     = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      active_r   <= '0;
      pend_vld_r <= 1'b0;
      nres_r     <= '0;
      q_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      pend_vld_r <= pend_vld_nxt;
      nres_r     <= nres_nxt;
      q_r        <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    dur_r  <= dur_nxt;
    ss_r   <= ss_nxt;
    nt_r   <= nt_nxt;
  end

`ifndef SYNTHESIS
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> out_free)
    else $error("result pushed while output register is held");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("held expiry left behind after a tick");

  a_create_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && state_r == ST_CREATE) |-> (res.last && state_nxt == ST_IDLE))
    else $error("create result not final");

  a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_WALK || state_r == ST_CREATE))
    else $error("slot memory written while idle");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= stb_pkg::RES_CNT_W'(stb_pkg::MAX_RESULTS))
    else $error("result count beyond limit");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the software timer bank. A directed sequence fills
// and empties the bank, hits bank-full, quiet ticks and a sixteen-expiry
// tick. A long result-side stall follows, then mostly random create and tick
// traffic. A local timer table predicts every result, and each result
// transfer is checked field by field in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RST_CYCLES   = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 230;
  localparam int STALL_ITEMS  = 20;
  // slots that may stay claimed forever (periodic or huge duration)
  localparam int PIN_BUDGET   = 8;
  localparam logic [7:0] RX_PATTERN = 8'b1011_0010;

  typedef struct {
    logic                      kind;
    logic [stb_pkg::DUR_W-1:0] duration;
    logic                      single_shot;
    logic                      notify;
  } timer_cmd_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [31:0] duration, [32] single_shot, [33] notify
  logic        in_tuser   = 1'b0; // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [3:0] slot
  logic [1:0]  out_tuser;         // [1:0] event_res
  logic        out_tlast;

  software_timer_bank_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the timer table
  bit                        tmr_active   [stb_pkg::NUM_TIMERS];
  logic                      tmr_single   [stb_pkg::NUM_TIMERS];
  logic                      tmr_notify   [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::DUR_W-1:0] tmr_duration [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::DUR_W-1:0] tmr_count    [stb_pkg::NUM_TIMERS];

  stb_pkg::stb_res_t pending_res[$];

  int fail_cnt    = 0;
  int n_items     = 0;
  int n_checked   = 0;
  int n_created   = 0;
  int n_full      = 0;
  int n_expired   = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;
  logic [7:0] rx_phase = '0;

  // Apply one accepted command to the local table and queue its results
  function automatic void apply_timer_cmd(input timer_cmd_t c);
    stb_pkg::stb_res_t r;
    int                free_idx;
    int                n_exp;
    free_idx = -1;
    n_exp    = 0;
    if (c.kind == stb_pkg::KIND_CREATE) begin
      for (int i = stb_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
        if (!tmr_active[i]) free_idx = i;
      end
      if (free_idx < 0) begin
        r.event_res = stb_pkg::EV_FULL;
        r.slot      = '0;
        n_full++;
      end else begin
        tmr_active[free_idx]   = 1'b1;
        tmr_duration[free_idx] = c.duration;
        tmr_single[free_idx]   = c.single_shot;
        tmr_notify[free_idx]   = c.notify;
        tmr_count[free_idx]    = '0;
        r.event_res = stb_pkg::EV_CREATED;
        r.slot      = stb_pkg::SLOT_W'(free_idx);
        n_created++;
      end
      r.last = 1'b1;
      pending_res.push_back(r);
    end else begin
      for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
        if (tmr_active[i]) begin
          tmr_count[i] = tmr_count[i] + 1'b1;
          if (tmr_count[i] >= tmr_duration[i]) begin
            tmr_count[i] = '0;
            if (tmr_single[i]) tmr_active[i] = 1'b0;
            if (tmr_notify[i] && n_exp < stb_pkg::MAX_RESULTS) begin
              r.event_res = stb_pkg::EV_EXPIRED;
              r.slot      = stb_pkg::SLOT_W'(i);
              r.last      = 1'b0;
              pending_res.push_back(r);
              n_exp++;
            end
          end
        end
      end
      // mark the final expiry of this tick
      if (n_exp > 0) begin
        r = pending_res.pop_back();
        r.last = 1'b1;
        pending_res.push_back(r);
        n_expired += n_exp;
      end
    end
  endfunction

  function automatic timer_cmd_t mk_cmd(input logic k,
                                        input logic [stb_pkg::DUR_W-1:0] dur,
                                        input logic ss, input logic ntf);
    timer_cmd_t c;
    c.kind        = k;
    c.duration    = dur;
    c.single_shot = ss;
    c.notify      = ntf;
    return c;
  endfunction

  // Offer one command; bursts of random length with random gaps between them
  task automatic send_cmd(input timer_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, c.notify, c.single_shot, c.duration};
    in_tuser  <= c.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_timer_cmd(c);
    n_items++;
  endtask

  // Stop offering and wait for every queued result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
  endtask

  // Fill the bank, overflow it, expire all sixteen in one tick, quiet ticks
  task automatic test_directed();
    for (int i = 0; i < stb_pkg::NUM_TIMERS; i++)
      send_cmd(mk_cmd(stb_pkg::KIND_CREATE, (i % 2 == 0) ? 32'd0 : 32'd1, 1'b1, 1'b1));
    // bank full
    send_cmd(mk_cmd(stb_pkg::KIND_CREATE, 32'd5, 1'b0, 1'b1));
    // all expire, fields ignored
    send_cmd(mk_cmd(stb_pkg::KIND_TICK, '1, 1'b1, 1'b1));
    // empty bank, quiet
    send_cmd(mk_cmd(stb_pkg::KIND_TICK, '0, 1'b0, 1'b0));
    // periodic, silent
    send_cmd(mk_cmd(stb_pkg::KIND_CREATE, 32'd1, 1'b0, 1'b0));
    // never expires
    send_cmd(mk_cmd(stb_pkg::KIND_CREATE, 32'hFFFF_FFFF, 1'b1, 1'b1));
    // silent expiry only
    send_cmd(mk_cmd(stb_pkg::KIND_TICK, '0, 1'b0, 1'b0));
    // fires on every tick
    send_cmd(mk_cmd(stb_pkg::KIND_CREATE, 32'd0, 1'b0, 1'b1));
    send_cmd(mk_cmd(stb_pkg::KIND_TICK, '0, 1'b0, 1'b0));
    send_cmd(mk_cmd(stb_pkg::KIND_CREATE, 32'd2, 1'b1, 1'b0));
    drain_results();
  endtask

  // Hold the result side for a long stretch while ticks keep coming
  task automatic test_long_stall();
    hold_req <= ~hold_req;
    for (int k = 0; k < STALL_ITEMS; k++) begin
      if (k % 7 == 3) send_cmd(mk_cmd(stb_pkg::KIND_CREATE, 32'(k % 4), 1'b1, 1'b1));
      else send_cmd(mk_cmd(stb_pkg::KIND_TICK, '0, 1'b0, 1'b0));
    end
    drain_results();
  endtask

  // Mostly short single-shot timers, a few periodic or huge ones
  task automatic test_random_traffic();
    timer_cmd_t c;
    int         sel;
    int         pins_left;
    pins_left = PIN_BUDGET - 3;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      sel = $urandom_range(0, 39);
      if (sel < 21) begin
        c = mk_cmd(stb_pkg::KIND_TICK, $urandom, 1'($urandom), 1'($urandom));
      end else if (sel == 21 && pins_left > 0) begin
        c = mk_cmd(stb_pkg::KIND_CREATE, $urandom_range(0, 12), 1'b0, 1'($urandom));
        pins_left--;
      end else if (sel == 22 && pins_left > 0) begin
        c = mk_cmd(stb_pkg::KIND_CREATE, $urandom, 1'b1, 1'($urandom));
        pins_left--;
      end else begin
        c = mk_cmd(stb_pkg::KIND_CREATE, $urandom_range(0, 15), 1'b1,
                   $urandom_range(0, 3) != 0);
      end
      send_cmd(c);
      if (k % 80 == 79) drain_results();
    end
    drain_results();
  endtask

  // Result side: long hold on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      case (rx_phase[7:6])
        2'd0: begin
          out_tready <= 1'b1;
        end
        2'd1: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        2'd2: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_tready <= RX_PATTERN[rx_phase[2:0]];
        end
      endcase
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    stb_pkg::stb_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result: event %0d slot %0d last %0d",
                 $time, out_tuser, out_tdata[3:0], out_tlast);
        fail_cnt++;
      end else begin
        exp_r = pending_res.pop_front();
        n_checked++;
        if (out_tuser !== exp_r.event_res) begin
          $display("%0t: event mismatch: expected %0d, actual %0d",
                   $time, exp_r.event_res, out_tuser);
          fail_cnt++;
        end
        if (out_tdata[3:0] !== exp_r.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d",
                   $time, exp_r.slot, out_tdata[3:0]);
          fail_cnt++;
        end
        if (out_tlast !== exp_r.last) begin
          $display("%0t: last mismatch: expected %0d, actual %0d",
                   $time, exp_r.last, out_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending_res.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_long_stall();
    test_random_traffic();

    // let a trailing quiet tick finish before the final check
    repeat (3 * stb_pkg::NUM_TIMERS) @(posedge clk);
    if (pending_res.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_res.size());
      fail_cnt++;
    end

    $display("Sent %0d items, checked %0d results", n_items, n_checked);
    $display("Predicted %0d creates, %0d bank-full, %0d expiries; %0d failures",
             n_created, n_full, n_expired, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
